// ===== design/grav_pkg.sv =====
`default_nettype none
package grav_pkg;

  localparam int POS_W  = 32;
  localparam int ABS_W  = 32;
  localparam int SQ_W   = 64;
  localparam int REM_W  = 66;
  localparam int ROOT_W = 34;
  localparam int D_W    = 33;
  localparam int DD_W   = 66;
  localparam int D3_W   = 99;
  localparam int DR_W   = 100;
  localparam int FAC_W  = 64;

  localparam logic [31:0] MAG_POS_LIM = 32'h7fff_ffff;
  localparam logic [31:0] MAG_NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic [31:0]        a_mass;
    logic [31:0]        b_mass;
    logic [31:0]        a_pull_gain;
    logic [31:0]        b_pull_gain;
  } item_t;

  typedef struct packed {
    logic signed [31:0] a_vel_dx;
    logic signed [31:0] a_vel_dy;
    logic signed [31:0] b_vel_dx;
    logic signed [31:0] b_vel_dy;
    logic signed [31:0] a_force_dx;
    logic signed [31:0] a_force_dy;
    logic signed [31:0] b_force_dx;
    logic signed [31:0] b_force_dy;
    logic               coincident;
    logic               saturated;
  } result_t;

  // per-item side data that rides along the pipeline
  typedef struct packed {
    logic              valid;
    logic              coin;
    logic              neg_x;
    logic              neg_y;
    logic [ABS_W-1:0]  ax;
    logic [ABS_W-1:0]  ay;
    logic [31:0]       a_mass;
    logic [31:0]       b_mass;
    logic [31:0]       a_gain;
    logic [31:0]       b_gain;
  } ctx_t;

endpackage
`default_nettype wire

// ===== design/gravity_pair_update_2d.sv =====
// throughput: one pair per cycle, busy stays low; the pipeline never stalls
// most of the pipeline length comes from the square-root cell chain (34 cells) and the divider
// cell chain (3*FRAC_BITS+1 cells), one result bit per cell
// reset: synchronous, clears the valid bits in every stage; done is low after it
`default_nettype none
module gravity_pair_update_2d #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire grav_pkg::item_t item,
  output logic                 done,
  output grav_pkg::result_t    result
);
  import grav_pkg::*;

  localparam int QW = 3 * FRAC_BITS + 1;
  localparam int QE = (QW > FAC_W + 1) ? QW : FAC_W + 1;
  localparam int NLANE = 4;
  localparam int TAIL = 4;

  // input stage
  logic [POS_W:0] dx;
  logic [POS_W:0] dy;
  ctx_t           ctx_new;

  ctx_t ctx1;
  ctx_t ctx2;
  ctx_t ctx3;
  logic [SQ_W-1:0]  sqx;
  logic [SQ_W-1:0]  sqy;
  logic [REM_W-1:0] d2;

  logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  ctx_t              sq_ctx  [0:ROOT_W];

  logic [D_W-1:0]  d_w;
  logic [D_W-1:0]  d4;
  logic [DD_W-1:0] dd;
  ctx_t            ctx4;
  logic [DD_W-1:0] plo;
  logic [DD_W-1:0] phi;
  ctx_t            ctx5;
  logic [D3_W-1:0] d3;
  ctx_t            ctx6;

  logic [D3_W-1:0] dv_d3  [0:QW];
  logic [DR_W-1:0] dv_rx  [0:QW];
  logic [DR_W-1:0] dv_ry  [0:QW];
  logic [QW-1:0]   dv_qx  [0:QW];
  logic [QW-1:0]   dv_qy  [0:QW];
  ctx_t            dv_ctx [0:QW];

  logic [QE-1:0]    qx_ext;
  logic [QE-1:0]    qy_ext;
  logic [FAC_W-1:0] fac_x;
  logic [FAC_W-1:0] fac_y;
  ctx_t             ctx7;

  logic [FAC_W-1:0]  ln_fac   [0:NLANE-1];
  logic              ln_neg   [0:NLANE-1];
  logic [31:0]       ln_gain  [0:NLANE-1];
  logic [31:0]       ln_mass  [0:NLANE-1];
  logic signed [31:0] ln_vel  [0:NLANE-1];
  logic signed [31:0] ln_force[0:NLANE-1];
  logic              ln_sat   [0:NLANE-1];

  logic tail_valid [0:TAIL-1];
  logic tail_coin  [0:TAIL-1];

  result_t result_next;

  assign busy = 1'b0;

  always_comb begin
    dx = {item.b_x[POS_W-1], item.b_x} - {item.a_x[POS_W-1], item.a_x};
    dy = {item.b_y[POS_W-1], item.b_y} - {item.a_y[POS_W-1], item.a_y};
    ctx_new.valid  = start & ~busy;
    ctx_new.coin   = (dx == '0) && (dy == '0);
    ctx_new.neg_x  = dx[POS_W];
    ctx_new.neg_y  = dy[POS_W];
    ctx_new.ax     = ABS_W'(dx[POS_W] ? (~dx + 1'b1) : dx);
    ctx_new.ay     = ABS_W'(dy[POS_W] ? (~dy + 1'b1) : dy);
    ctx_new.a_mass = item.a_mass;
    ctx_new.b_mass = item.b_mass;
    ctx_new.a_gain = item.a_pull_gain;
    ctx_new.b_gain = item.b_pull_gain;
  end

  // squares and sum of squares
  always_ff @(posedge clk) begin
    sqx  <= SQ_W'(ctx1.ax) * SQ_W'(ctx1.ax);
    sqy  <= SQ_W'(ctx1.ay) * SQ_W'(ctx1.ay);
    d2   <= REM_W'(sqx) + REM_W'(sqy);
    if (rst) begin
      ctx1 <= '0;
      ctx2 <= '0;
      ctx3 <= '0;
    end else begin
      ctx1 <= ctx_new;
      ctx2 <= ctx1;
      ctx3 <= ctx2;
    end
  end

  // square root, one root bit per cell
  assign sq_rem[0]  = d2;
  assign sq_root[0] = '0;
  assign sq_ctx[0]  = ctx3;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    grav_sqrt_cell #(
      .BIT(ROOT_W - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .rem_in  (sq_rem[k]),
      .root_in (sq_root[k]),
      .ctx_in  (sq_ctx[k]),
      .rem_out (sq_rem[k+1]),
      .root_out(sq_root[k+1]),
      .ctx_out (sq_ctx[k+1])
    );
  end

  assign d_w = D_W'(sq_root[ROOT_W]);

  // d cubed in two partial products
  always_ff @(posedge clk) begin
    dd   <= DD_W'(d_w) * DD_W'(d_w);
    d4   <= d_w;
    plo  <= DD_W'(dd[D_W-1:0]) * DD_W'(d4);
    phi  <= DD_W'(dd[DD_W-1:D_W]) * DD_W'(d4);
    d3   <= (D3_W'(phi) << D_W) + D3_W'(plo);
    if (rst) begin
      ctx4 <= '0;
      ctx5 <= '0;
      ctx6 <= '0;
    end else begin
      ctx4 <= sq_ctx[ROOT_W];
      ctx5 <= ctx4;
      ctx6 <= ctx5;
    end
  end

  // |delta| * 2^(3F) / d^3, one quotient bit per cell
  assign dv_d3[0]  = d3;
  assign dv_rx[0]  = DR_W'(ctx6.ax >> 1);
  assign dv_ry[0]  = DR_W'(ctx6.ay >> 1);
  assign dv_qx[0]  = '0;
  assign dv_qy[0]  = '0;
  assign dv_ctx[0] = ctx6;

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic bx;
    logic by;
    if (k == 0) begin : g_first
      assign bx = dv_ctx[0].ax[0];
      assign by = dv_ctx[0].ay[0];
    end else begin : g_rest
      assign bx = 1'b0;
      assign by = 1'b0;
    end
    grav_div_cell #(
      .QW(QW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .d3_in  (dv_d3[k]),
      .rx_in  (dv_rx[k]),
      .ry_in  (dv_ry[k]),
      .bx_in  (bx),
      .by_in  (by),
      .qx_in  (dv_qx[k]),
      .qy_in  (dv_qy[k]),
      .ctx_in (dv_ctx[k]),
      .d3_out (dv_d3[k+1]),
      .rx_out (dv_rx[k+1]),
      .ry_out (dv_ry[k+1]),
      .qx_out (dv_qx[k+1]),
      .qy_out (dv_qy[k+1]),
      .ctx_out(dv_ctx[k+1])
    );
  end

  assign qx_ext = QE'(dv_qx[QW]);
  assign qy_ext = QE'(dv_qy[QW]);

  always_ff @(posedge clk) begin
    fac_x <= (|qx_ext[QE-1:FAC_W]) ? '1 : qx_ext[FAC_W-1:0];
    fac_y <= (|qy_ext[QE-1:FAC_W]) ? '1 : qy_ext[FAC_W-1:0];
    if (rst) begin
      ctx7 <= '0;
    end else begin
      ctx7 <= dv_ctx[QW];
    end
  end

  // lanes: a x, a y, b x, b y
  always_comb begin
    ln_fac[0]  = fac_x;
    ln_neg[0]  = ctx7.neg_x;
    ln_gain[0] = ctx7.b_gain;
    ln_mass[0] = ctx7.a_mass;
    ln_fac[1]  = fac_y;
    ln_neg[1]  = ctx7.neg_y;
    ln_gain[1] = ctx7.b_gain;
    ln_mass[1] = ctx7.a_mass;
    ln_fac[2]  = fac_x;
    ln_neg[2]  = ~ctx7.neg_x;
    ln_gain[2] = ctx7.a_gain;
    ln_mass[2] = ctx7.b_mass;
    ln_fac[3]  = fac_y;
    ln_neg[3]  = ~ctx7.neg_y;
    ln_gain[3] = ctx7.a_gain;
    ln_mass[3] = ctx7.b_mass;
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    grav_axis #(
      .FRAC_BITS(FRAC_BITS)
    ) u_axis (
      .clk      (clk),
      .fac      (ln_fac[k]),
      .neg      (ln_neg[k]),
      .gain     (ln_gain[k]),
      .mass     (ln_mass[k]),
      .vel      (ln_vel[k]),
      .force_inc(ln_force[k]),
      .sat      (ln_sat[k])
    );
  end

  always_ff @(posedge clk) begin
    tail_coin[0] <= ctx7.coin;
    for (int i = 1; i < TAIL; i++) begin
      tail_coin[i] <= tail_coin[i-1];
    end
    if (rst) begin
      for (int i = 0; i < TAIL; i++) begin
        tail_valid[i] <= 1'b0;
      end
    end else begin
      tail_valid[0] <= ctx7.valid;
      for (int i = 1; i < TAIL; i++) begin
        tail_valid[i] <= tail_valid[i-1];
      end
    end
  end

  // result register
  always_comb begin
    result_next = '0;
    if (tail_coin[TAIL-1]) begin
      result_next.coincident = 1'b1;
    end else begin
      result_next.a_vel_dx   = ln_vel[0];
      result_next.a_vel_dy   = ln_vel[1];
      result_next.b_vel_dx   = ln_vel[2];
      result_next.b_vel_dy   = ln_vel[3];
      result_next.a_force_dx = ln_force[0];
      result_next.a_force_dy = ln_force[1];
      result_next.b_force_dx = ln_force[2];
      result_next.b_force_dy = ln_force[3];
      result_next.coincident = 1'b0;
      result_next.saturated  = ln_sat[0] | ln_sat[1] | ln_sat[2] | ln_sat[3];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail_valid[TAIL-1];
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("transfer strobe after reset");

  a_coin_no_sat: assert property (@(posedge clk) disable iff (rst)
    done && result.coincident |-> !result.saturated && result.a_vel_dx == 0
      && result.b_force_dy == 0)
    else $error("coincident transfer carries nonzero data");

  a_done_tracks_tail: assert property (@(posedge clk) disable iff (rst)
    tail_valid[TAIL-1] |=> done)
    else $error("lost transfer at output");

endmodule
`default_nettype wire

// ===== design/grav_sqrt_cell.sv =====
`default_nettype none
module grav_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [grav_pkg::REM_W-1:0]  rem_in,
  input  wire logic [grav_pkg::ROOT_W-1:0] root_in,
  input  wire grav_pkg::ctx_t              ctx_in,
  output logic [grav_pkg::REM_W-1:0]       rem_out,
  output logic [grav_pkg::ROOT_W-1:0]      root_out,
  output grav_pkg::ctx_t                   ctx_out
);
  import grav_pkg::*;

  localparam int TW = REM_W + 4;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_ext;
  logic          fits;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  always_comb begin
    rem_ext = TW'(rem_in);
    trial   = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    fits    = (trial <= rem_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out <= '0;
    end else begin
      ctx_out <= ctx_in;
    end
    if (fits) begin
      rem_out  <= REM_W'(rem_ext - trial);
      root_out <= root_in | (ROOT_W'(1) << BIT);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/grav_div_cell.sv =====
`default_nettype none
module grav_div_cell #(
  parameter int QW = 49
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [grav_pkg::D3_W-1:0] d3_in,
  input  wire logic [grav_pkg::DR_W-1:0] rx_in,
  input  wire logic [grav_pkg::DR_W-1:0] ry_in,
  input  wire logic                      bx_in,
  input  wire logic                      by_in,
  input  wire logic [QW-1:0]             qx_in,
  input  wire logic [QW-1:0]             qy_in,
  input  wire grav_pkg::ctx_t            ctx_in,
  output logic [grav_pkg::D3_W-1:0]      d3_out,
  output logic [grav_pkg::DR_W-1:0]      rx_out,
  output logic [grav_pkg::DR_W-1:0]      ry_out,
  output logic [QW-1:0]                  qx_out,
  output logic [QW-1:0]                  qy_out,
  output grav_pkg::ctx_t                 ctx_out
);
  import grav_pkg::*;

  logic [DR_W-1:0] tx;
  logic [DR_W-1:0] ty;
  logic [DR_W-1:0] den;
  logic            gx;
  logic            gy;

  always_comb begin
    den = DR_W'(d3_in);
    tx  = {rx_in[DR_W-2:0], bx_in};
    ty  = {ry_in[DR_W-2:0], by_in};
    gx  = (tx >= den);
    gy  = (ty >= den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out <= '0;
    end else begin
      ctx_out <= ctx_in;
    end
    d3_out  <= d3_in;
    rx_out  <= gx ? (tx - den) : tx;
    ry_out  <= gy ? (ty - den) : ty;
    qx_out  <= {qx_in[QW-2:0], gx};
    qy_out  <= {qy_in[QW-2:0], gy};
  end

endmodule
`default_nettype wire

// ===== design/grav_axis.sv =====
`default_nettype none
module grav_axis #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic [grav_pkg::FAC_W-1:0] fac,
  input  wire logic                       neg,
  input  wire logic [31:0]                gain,
  input  wire logic [31:0]                mass,
  output logic signed [31:0]              vel,
  output logic signed [31:0]              force_inc,
  output logic                            sat
);
  import grav_pkg::*;

  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic        neg1;
  logic [31:0] mass1;

  logic [95:0] prod;
  logic [95:0] vmag;
  logic [31:0] lim1;

  logic [31:0] vm2;
  logic        neg2;
  logic        sat2;
  logic [31:0] mass2;

  logic [63:0] fp3;
  logic [31:0] vm3;
  logic        neg3;
  logic        sat3;

  logic [63:0] fmag;
  logic [31:0] lim3;
  logic        fclip;

  always_comb begin
    prod  = {p_hi, 32'd0} + 96'(p_lo);
    vmag  = prod >> FRAC_BITS;
    lim1  = neg1 ? MAG_NEG_LIM : MAG_POS_LIM;
    fmag  = fp3 >> FRAC_BITS;
    lim3  = neg3 ? MAG_NEG_LIM : MAG_POS_LIM;
    fclip = (fmag > 64'(lim3));
  end

  always_ff @(posedge clk) begin
    p_lo  <= 64'(fac[31:0]) * 64'(gain);
    p_hi  <= 64'(fac[63:32]) * 64'(gain);
    neg1  <= neg;
    mass1 <= mass;

    if (vmag > 96'(lim1)) begin
      vm2  <= lim1;
      sat2 <= 1'b1;
    end else begin
      vm2  <= vmag[31:0];
      sat2 <= 1'b0;
    end
    neg2  <= neg1;
    mass2 <= mass1;

    fp3  <= 64'(vm2) * 64'(mass2);
    vm3  <= vm2;
    neg3 <= neg2;
    sat3 <= sat2;

    vel       <= neg3 ? (32'd0 - vm3) : vm3;
    force_inc <= neg3 ? (32'd0 - (fclip ? lim3 : fmag[31:0])) : (fclip ? lim3 : fmag[31:0]);
    sat       <= sat3 | fclip;
  end

endmodule
`default_nettype wire
